@@ sv/affine_tsr_decompose_defines.svh @@
// Assertion macros for the affine decomposition block
`ifndef AFFINE_TSR_DECOMPOSE_DEFINES_SVH
`define AFFINE_TSR_DECOMPOSE_DEFINES_SVH
`ifndef SYNTHESIS
`define ATD_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ATD_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define ATD_ASSERT_IMPL(label, clk, rst_n, prop)
`define ATD_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

@@ sv/atd_pkg.sv @@
package atd_pkg;
    localparam int FracBits   = 16;
    localparam int Iters      = 30;
    localparam int AngW       = 34;
    localparam int CordW      = 44;
    localparam int StageCnt   = 8;
    localparam int IterPerSt  = 4;
    localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;
    localparam logic signed [20:0] ScaleLim = 21'sd1048575;
    localparam logic signed [18:0] RotLim   = 19'sd262143;
    localparam logic [15:0] TolReset = 16'd66;

    typedef logic signed [CordW-1:0] t_cord;
    typedef logic signed [AngW-1:0]  t_ang;

    function automatic t_ang atan_tab(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314857;   1: v = 32'd497837829;
            2: v = 32'd263043837;   3: v = 32'd133525159;
            4: v = 32'd67021687;    5: v = 32'd33543516;
            6: v = 32'd16775851;    7: v = 32'd8388437;
            8: v = 32'd4194283;     9: v = 32'd2097149;
            default: v = (i < 30) ? (32'd1 << (30 - i)) : 32'd0;
        endcase
        return t_ang'({2'b00, v});
    endfunction
endpackage

@@ sv/affine_tsr_decompose.sv @@
// Each accepted word passes the entry registers, the stage registers and the output registers before o_valid rises.
// Throughput: one word accepted every cycle, set by the 8-stage CORDIC pipeline
// (4 iterations per stage, 30 iterations) running four atan2 lanes plus square-root lanes.
// busy is always low: the receiver cannot stall and nothing backs up.
// Synchronous active-low reset clears valid bits and sets tolerance to 66.
`include "affine_tsr_decompose_defines.svh"
module affine_tsr_decompose (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  logic signed [19:0] i_lin_a,
    input  logic signed [19:0] i_lin_b,
    input  logic signed [19:0] i_lin_c,
    input  logic signed [19:0] i_lin_d,
    input  logic signed [31:0] i_shift_x_in,
    input  logic signed [31:0] i_shift_y_in,
    output logic               o_valid,
    output logic signed [31:0] o_shift_x_out,
    output logic signed [31:0] o_shift_y_out,
    output logic signed [20:0] o_scale_x_out,
    output logic signed [20:0] o_scale_y_out,
    output logic signed [18:0] o_rotation_out,
    output logic               o_degenerate
);
    localparam int NS = atd_pkg::StageCnt;
    localparam int NL = 4;

    logic [15:0] r_tol;
    // Stage registers: index 0 is the entry stage
    logic                   r_v   [NS+1];
    atd_pkg::t_cord         r_x   [NS+1][NL];
    atd_pkg::t_cord         r_y   [NS+1][NL];
    atd_pkg::t_ang          r_z   [NS+1][NL];
    logic [40:0]            r_nx  [NS+1];
    logic [40:0]            r_ny  [NS+1];
    logic [41:0]            r_rx  [NS+1];
    logic [41:0]            r_ry  [NS+1];
    logic [41:0]            r_bx  [NS+1];
    logic [41:0]            r_by  [NS+1];
    logic                   r_dg  [NS+1];
    logic signed [31:0]     r_tx  [NS+1];
    logic signed [31:0]     r_ty  [NS+1];

    assign busy = 1'b0;

    // Hold the tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tol <= atd_pkg::TolReset;
        else if (i_cfg_we) r_tol <= i_cfg_wdata;
    end

    // Entry: squares, prerotation by pi for negative x
    // Widen before negating so -2^19 keeps its magnitude
    logic signed [20:0] wy [NL];
    logic signed [20:0] wx [NL];
    always_comb begin
        wy[0] = 21'(i_lin_b);  wx[0] = 21'(i_lin_a);
        wy[1] = -21'(i_lin_b); wx[1] = -21'(i_lin_a);
        wy[2] = -21'(i_lin_c); wx[2] = 21'(i_lin_d);
        wy[3] = 21'(i_lin_c);  wx[3] = -21'(i_lin_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v[0] <= 1'b0;
        else r_v[0] <= start;
        for (int l = 0; l < NL; l++) begin
            if (wx[l] < 0) begin
                r_x[0][l] <= -(atd_pkg::t_cord'(wx[l]) <<< 20);
                r_y[0][l] <= -(atd_pkg::t_cord'(wy[l]) <<< 20);
                r_z[0][l] <= (wy[l] >= 0) ? atd_pkg::PiQ30 : -atd_pkg::PiQ30;
            end else begin
                r_x[0][l] <= atd_pkg::t_cord'(wx[l]) <<< 20;
                r_y[0][l] <= atd_pkg::t_cord'(wy[l]) <<< 20;
                r_z[0][l] <= '0;
            end
        end
        r_nx[0] <= 41'(40'($signed(i_lin_a) * $signed(i_lin_a)))
                 + 41'(40'($signed(i_lin_b) * $signed(i_lin_b)));
        r_ny[0] <= 41'(40'($signed(i_lin_c) * $signed(i_lin_c)))
                 + 41'(40'($signed(i_lin_d) * $signed(i_lin_d)));
        r_rx[0] <= '0;
        r_ry[0] <= '0;
        r_bx[0] <= 42'd1 << 40;
        r_by[0] <= 42'd1 << 40;
        r_dg[0] <= (i_lin_a == 0 && i_lin_b == 0) || (i_lin_c == 0 && i_lin_d == 0);
        r_tx[0] <= i_shift_x_in;
        r_ty[0] <= i_shift_y_in;
    end

    // CORDIC stages of four iterations each, with three square-root steps per stage
    for (genvar s = 0; s < NS; s++) begin : g_st
        atd_pkg::t_cord cx [NL][5];
        atd_pkg::t_cord cy [NL][5];
        atd_pkg::t_ang  cz [NL][5];
        logic [41:0] qn [2][4];
        logic [41:0] qr [2][4];
        logic [41:0] qb [2][4];
        logic [41:0] tmp;
        always_comb begin
            tmp = '0;
            for (int l = 0; l < NL; l++) begin
                cx[l][0] = r_x[s][l]; cy[l][0] = r_y[s][l]; cz[l][0] = r_z[s][l];
                for (int k = 0; k < 4; k++) begin
                    if (s*4 + k < atd_pkg::Iters) begin
                        if (cy[l][k] >= 0) begin
                            cx[l][k+1] = cx[l][k] + (cy[l][k] >>> (s*4+k));
                            cy[l][k+1] = cy[l][k] - (cx[l][k] >>> (s*4+k));
                            cz[l][k+1] = cz[l][k] + atd_pkg::atan_tab(s*4+k);
                        end else begin
                            cx[l][k+1] = cx[l][k] - (cy[l][k] >>> (s*4+k));
                            cy[l][k+1] = cy[l][k] + (cx[l][k] >>> (s*4+k));
                            cz[l][k+1] = cz[l][k] - atd_pkg::atan_tab(s*4+k);
                        end
                    end else begin
                        cx[l][k+1] = cx[l][k]; cy[l][k+1] = cy[l][k];
                        cz[l][k+1] = cz[l][k];
                    end
                end
            end
            // Digit-by-digit square root, bit pairs 40..0 (21 steps over 8 stages)
            qn[0][0] = 42'(r_nx[s]); qr[0][0] = r_rx[s]; qb[0][0] = r_bx[s];
            qn[1][0] = 42'(r_ny[s]); qr[1][0] = r_ry[s]; qb[1][0] = r_by[s];
            for (int m = 0; m < 2; m++) begin
                for (int k = 0; k < 3; k++) begin
                    tmp = qr[m][k] + qb[m][k];
                    // hold the finished root once the bit runs out
                    if (qb[m][k] == 0) begin
                        qn[m][k+1] = qn[m][k];
                        qr[m][k+1] = qr[m][k];
                    end else if (qn[m][k] >= tmp) begin
                        qn[m][k+1] = qn[m][k] - tmp;
                        qr[m][k+1] = (qr[m][k] >> 1) + qb[m][k];
                    end else begin
                        qn[m][k+1] = qn[m][k];
                        qr[m][k+1] = qr[m][k] >> 1;
                    end
                    qb[m][k+1] = qb[m][k] >> 2;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[s+1] <= 1'b0;
            else r_v[s+1] <= r_v[s];
            for (int l = 0; l < NL; l++) begin
                r_x[s+1][l] <= cx[l][4];
                r_y[s+1][l] <= cy[l][4];
                r_z[s+1][l] <= cz[l][4];
            end
            r_nx[s+1] <= qn[0][3][40:0]; r_rx[s+1] <= qr[0][3];
            r_bx[s+1] <= qb[0][3];
            r_ny[s+1] <= qn[1][3][40:0]; r_ry[s+1] <= qr[1][3];
            r_by[s+1] <= qb[1][3];
            r_dg[s+1] <= r_dg[s];
            r_tx[s+1] <= r_tx[s];
            r_ty[s+1] <= r_ty[s];
        end
    end

    // Final stage: clamp, round angles, round roots, pick pair
    atd_pkg::t_ang zc [NL];
    logic signed [19:0] ang [NL];
    logic signed [21:0] mx, my;
    logic signed [20:0] sx, sy, mxs, mys;
    logic signed [19:0] rot;
    logic [20:0] d00, d01, d10;
    logic signed [20:0] df;
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            zc[l] = r_z[NS][l];
            if (zc[l] > atd_pkg::PiQ30) zc[l] = atd_pkg::PiQ30;
            if (zc[l] < -atd_pkg::PiQ30) zc[l] = -atd_pkg::PiQ30;
            ang[l] = 20'((zc[l] + 34'sd8192) >>> 14);
        end
        // root remainder = n - r*r; round up when it exceeds r
        mx = (42'(r_nx[NS]) > r_rx[NS]) ? 22'(r_rx[NS]) + 22'sd1 : 22'(r_rx[NS]);
        my = (42'(r_ny[NS]) > r_ry[NS]) ? 22'(r_ry[NS]) + 22'sd1 : 22'(r_ry[NS]);
        mxs = (mx > 22'(atd_pkg::ScaleLim)) ? atd_pkg::ScaleLim : 21'(mx);
        mys = (my > 22'(atd_pkg::ScaleLim)) ? atd_pkg::ScaleLim : 21'(my);
        df = 21'(ang[0]) - 21'(ang[2]); d00 = df[20] ? 21'(-df) : 21'(df);
        df = 21'(ang[0]) - 21'(ang[3]); d01 = df[20] ? 21'(-df) : 21'(df);
        df = 21'(ang[1]) - 21'(ang[2]); d10 = df[20] ? 21'(-df) : 21'(df);
        if (d00 < 21'(r_tol)) begin
            sx = mxs; sy = mys; rot = ang[0];
        end else if (d01 < 21'(r_tol)) begin
            sx = mxs; sy = -mys; rot = ang[0];
        end else if (d10 < 21'(r_tol)) begin
            sx = -mxs; sy = mys; rot = ang[1];
        end else begin
            sx = -mxs; sy = -mys; rot = ang[1];
        end
        if (rot > 20'(atd_pkg::RotLim)) rot = 20'(atd_pkg::RotLim);
        if (rot < -20'(atd_pkg::RotLim)) rot = -20'(atd_pkg::RotLim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= r_v[NS];
        o_shift_x_out <= r_tx[NS];
        o_shift_y_out <= r_ty[NS];
        o_degenerate  <= r_dg[NS];
        if (r_dg[NS]) begin
            o_scale_x_out  <= 21'sd65536;
            o_scale_y_out  <= 21'sd65536;
            o_rotation_out <= '0;
        end else begin
            o_scale_x_out  <= sx;
            o_scale_y_out  <= sy;
            o_rotation_out <= 19'(rot);
        end
    end

    `ATD_ASSERT_NEXT(a_valid_follows, i_clk, i_rst_n, r_v[NS], o_valid)
    `ATD_ASSERT_IMPL(a_degen_scale, i_clk, i_rst_n, (o_valid && o_degenerate) |-> (o_scale_x_out == 21'sd65536 && o_rotation_out == 19'sd0))
    `ATD_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, !busy)
endmodule
